/* hw/rtl/ihbh_pkg.sv */
// Package for the histogram bar-height engine: item type, action codes, luma weights.
// No dependencies.
`default_nettype none
package ihbh_pkg;
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [7:0] LUMA_WR = 8'd77;
	localparam logic [7:0] LUMA_WG = 8'd150;
	localparam logic [7:0] LUMA_WB = 8'd29;

	localparam int HEIGHT_BITS = 10;
	localparam int LANES       = 5;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] luma;
		logic [7:0] bin;
	} ihbh_item_t;
endpackage
`default_nettype wire

/* hw/rtl/image_histogram_bar_heights_top.sv */
// Top level of the histogram bar-height engine: mode register, front end, queue, back end.
// Depends on ihbh_pkg, ihbh_front, ihbh_queue, ihbh_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: action, blue_or_gray, green, red, bin.
//   Actions: clear all tables, add one pixel, read the bar heights of one bin, or none.
//   Only a read produces a result item on the output channel (out_valid / out_stall).
//   cfg_valid / cfg_ready writes color_mode (cfg_data); cfg_ready is always high.
//   Write it only while no item is in flight.
// Operation:
//   The front end registers each item and computes luma, then a two-entry queue feeds the back
//   end, so the input keeps flowing while the back end works.
//   Back end: a clear runs a pass that zeroes one table entry a cycle, an add reads the
//   table, then writes back and updates the maxima, and a read runs the restoring divider,
//   five lanes running in parallel, and waits for the output register to be free.
// Reset: a clearing pass zeroes the tables; maxima zero, gray mode. Items are
//   accepted meanwhile until front end and queue are full, then in_stall rises.
// Output stall: the result is held in the output register; the back end keeps going until
//   it has a next result and the register is still full, then the queue fills and in_stall rises.
`default_nettype none
module image_histogram_bar_heights_top import ihbh_pkg::*; #(
	parameter int BAR_HEIGHT = 512,
	parameter int COUNT_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             action,
	input  wire logic [7:0]             blue_or_gray,
	input  wire logic [7:0]             green,
	input  wire logic [7:0]             red,
	input  wire logic [7:0]             bin,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [HEIGHT_BITS-1:0]      gray_or_blue_height,
	output logic [HEIGHT_BITS-1:0]      green_height,
	output logic [HEIGHT_BITS-1:0]      red_height,
	output logic [HEIGHT_BITS-1:0]      luma_shared_height,
	output logic [HEIGHT_BITS-1:0]      luma_own_height
);
	logic       color_mode_q;
	logic       push, q_full, pop, q_not_empty;
	ihbh_item_t push_item, q_head;

	assign cfg_ready = 1'b1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			color_mode_q <= cfg_data;
		end
	end

	ihbh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.blue_or_gray (blue_or_gray),
		.green        (green),
		.red          (red),
		.bin          (bin),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	ihbh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	ihbh_back #(.BAR_HEIGHT(BAR_HEIGHT), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.color_mode          (color_mode_q),
		.q_not_empty         (q_not_empty),
		.q_head              (q_head),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.gray_or_blue_height (gray_or_blue_height),
		.green_height        (green_height),
		.red_height          (red_height),
		.luma_shared_height  (luma_shared_height),
		.luma_own_height     (luma_own_height)
	);
endmodule
`default_nettype wire

/* hw/rtl/ihbh_front.sv */
// Front end: accepts items, derives luma, and holds one item for the queue.
// Depends on ihbh_pkg.
`default_nettype none
module ihbh_front import ihbh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] action,
	input  wire logic [7:0] blue_or_gray,
	input  wire logic [7:0] green,
	input  wire logic [7:0] red,
	input  wire logic [7:0] bin,
	output logic            push,
	output ihbh_item_t      push_item,
	input  wire logic       q_full
);
	logic        valid_s1;
	ihbh_item_t  item_s1;
	logic [15:0] luma_sum;
	logic        take;

	// luma = (77R + 150G + 29B) >> 8; the sum tops out at 256 * 255
	assign luma_sum = 16'(red) * 16'(LUMA_WR) + 16'(green) * 16'(LUMA_WG)
		+ 16'(blue_or_gray) * 16'(LUMA_WB);

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign in_stall  = valid_s1 && q_full;
	assign take      = in_valid && !in_stall;

	// one stage toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{action: action, blue: blue_or_gray, green: green, red: red,
				luma: luma_sum[15:8], bin: bin};
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ihbh_queue.sv */
// Two-entry item queue between front and back end.
// Depends on ihbh_pkg.
`default_nettype none
module ihbh_queue import ihbh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire ihbh_item_t push_item,
	output logic            full,
	input  wire logic       pop,
	output logic            not_empty,
	output ihbh_item_t      head
);
	ihbh_item_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

/* hw/rtl/ihbh_div.sv */
// Restoring divider, one quotient bit a cycle; quotient saturates at 1023, zero divisor gives 0.
// Depends on ihbh_pkg.
`default_nettype none
module ihbh_div import ihbh_pkg::*; #(
	parameter int DW = 34,
	parameter int CB = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [DW-1:0]          dividend,
	input  wire logic [CB-1:0]          divisor,
	output logic                        busy,
	output logic [HEIGHT_BITS-1:0]      quot
);
	localparam int W = DW + HEIGHT_BITS;
	localparam logic [3:0] FIRST = 4'(HEIGHT_BITS);

	logic [W-1:0]             rem_q, dsh_q;
	logic [HEIGHT_BITS-1:0]   q_q;
	logic [3:0]               cnt_q;
	logic                     busy_q;
	logic                     ge;

	assign ge   = (rem_q >= dsh_q);
	assign busy = busy_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= FIRST;
		end else if (busy_q) begin
			// first step checks zero divisor and overflow of the quotient
			if (cnt_q == FIRST) begin
				if (dsh_q == '0 || ge) busy_q <= 1'b0;
				else                   cnt_q  <= cnt_q - 4'd1;
			end else if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(dividend);
			dsh_q <= W'(divisor) << HEIGHT_BITS;
			q_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q == FIRST) begin
				if (dsh_q == '0) q_q <= '0;
				else if (ge)     q_q <= '1;
				dsh_q <= dsh_q >> 1;
			end else begin
				if (ge) rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[HEIGHT_BITS-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ihbh_back.sv */
// Back end: count tables, running maxima, and bar-height computation for reads.
// Depends on ihbh_pkg and ihbh_div.
`default_nettype none
module ihbh_back import ihbh_pkg::*; #(
	parameter int BAR_HEIGHT = 512,
	parameter int COUNT_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   color_mode,
	input  wire logic                   q_not_empty,
	input  wire ihbh_item_t             q_head,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [HEIGHT_BITS-1:0]      gray_or_blue_height,
	output logic [HEIGHT_BITS-1:0]      green_height,
	output logic [HEIGHT_BITS-1:0]      red_height,
	output logic [HEIGHT_BITS-1:0]      luma_shared_height,
	output logic [HEIGHT_BITS-1:0]      luma_own_height
);
	localparam int CB = COUNT_BITS;
	localparam int HB = $clog2(BAR_HEIGHT + 1);
	localparam int DW = CB + HB;
	localparam logic [HB-1:0] BARV = HB'(BAR_HEIGHT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_CLR  = 2'd3;

	logic [1:0] state_q;
	ihbh_item_t item_q;
	logic [7:0] clr_addr_q;

	logic [CB-1:0] mem_b [256];
	logic [CB-1:0] mem_g [256];
	logic [CB-1:0] mem_r [256];
	logic [CB-1:0] mem_l [256];
	logic [CB-1:0] rd_b_q, rd_g_q, rd_r_q, rd_l_q;
	logic [CB-1:0] shared_max_q, luma_max_q;

	logic [7:0]    ab, ag, ar, al;
	logic [CB-1:0] cb, cg, cr, cl;
	logic [CB-1:0] nb, ng, nr, nl;
	logic [CB-1:0] shared_nx, luma_nx;
	logic          is_add, wr_en, wr_color;
	logic          clr_en, we_b, we_c;
	logic [7:0]    wa_b, wa_g, wa_r, wa_l;
	logic [CB-1:0] wd_b, wd_g, wd_r, wd_l;

	logic [CB-1:0]          lane_cnt [LANES];
	logic [CB-1:0]          lane_div [LANES];
	logic [LANES-1:0]       lane_busy;
	logic [HEIGHT_BITS-1:0] lane_q [LANES];
	logic                   div_start;
	logic [CB-1:0]          gray_div;

	logic                   out_valid_q;
	logic [HEIGHT_BITS-1:0] out_h_q [LANES];
	logic                   out_free;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (v == '1) ? v : v + CB'(1);
	endfunction

	function automatic logic [CB-1:0] max2(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// table addresses: pixel samples on add, bin on read
	always_comb begin
		if (q_head.action == ACT_ADD) begin
			ab = q_head.blue;
			ag = q_head.green;
			ar = q_head.red;
			al = q_head.luma;
		end else begin
			ab = q_head.bin;
			ag = q_head.bin;
			ar = q_head.bin;
			al = q_head.bin;
		end
	end

	assign pop      = (state_q == ST_IDLE) && q_not_empty;
	assign out_free = !out_valid_q || !out_stall;

	// counts of the held item
	assign is_add = (item_q.action == ACT_ADD);
	assign cb = rd_b_q;
	assign cg = rd_g_q;
	assign cr = rd_r_q;
	assign cl = rd_l_q;

	assign nb = sat_inc(cb);
	assign ng = sat_inc(cg);
	assign nr = sat_inc(cr);
	assign nl = sat_inc(cl);

	assign wr_en    = (state_q == ST_EXEC) && is_add;
	assign wr_color = wr_en && color_mode;

	// write port: clearing pass zeroes one entry a cycle, otherwise add write-back
	assign clr_en = (state_q == ST_CLR);
	assign we_b   = wr_en || clr_en;
	assign we_c   = wr_color || clr_en;
	assign wa_b   = clr_en ? clr_addr_q : item_q.blue;
	assign wa_g   = clr_en ? clr_addr_q : item_q.green;
	assign wa_r   = clr_en ? clr_addr_q : item_q.red;
	assign wa_l   = clr_en ? clr_addr_q : item_q.luma;
	assign wd_b   = clr_en ? '0 : nb;
	assign wd_g   = clr_en ? '0 : ng;
	assign wd_r   = clr_en ? '0 : nr;
	assign wd_l   = clr_en ? '0 : nl;

	// new maxima after an add
	always_comb begin
		if (color_mode) begin
			shared_nx = max2(max2(shared_max_q, nb), max2(max2(ng, nr), nl));
			luma_nx   = max2(luma_max_q, nl);
		end else begin
			shared_nx = max2(shared_max_q, nb);
			luma_nx   = luma_max_q;
		end
	end

	// count memories
	always_ff @(posedge clk) begin
		if (pop) rd_b_q <= mem_b[ab];
		if (we_b) mem_b[wa_b] <= wd_b;
	end
	always_ff @(posedge clk) begin
		if (pop) rd_g_q <= mem_g[ag];
		if (we_c) mem_g[wa_g] <= wd_g;
	end
	always_ff @(posedge clk) begin
		if (pop) rd_r_q <= mem_r[ar];
		if (we_c) mem_r[wa_r] <= wd_r;
	end
	always_ff @(posedge clk) begin
		if (pop) rd_l_q <= mem_l[al];
		if (we_c) mem_l[wa_l] <= wd_l;
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= q_head;
	end

	// sequencer, clearing pass and maxima
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_addr_q   <= '0;
			shared_max_q <= '0;
			luma_max_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_head.action == ACT_CLEAR) begin
							state_q      <= ST_CLR;
							clr_addr_q   <= '0;
							shared_max_q <= '0;
							luma_max_q   <= '0;
						end else if (q_head.action == ACT_ADD || q_head.action == ACT_READ) begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (is_add) begin
						shared_max_q <= shared_nx;
						luma_max_q   <= luma_nx;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (lane_busy == '0 && out_free) state_q <= ST_IDLE;
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 8'd1;
					if (clr_addr_q == 8'd255) state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider lanes: blue/gray, green, red, luma/shared max, luma/own max or gray
	assign div_start = (state_q == ST_EXEC) && !is_add;
	assign gray_div  = (shared_max_q == '0) ? CB'(1) : shared_max_q;

	always_comb begin
		lane_cnt[0] = cb;
		lane_cnt[1] = cg;
		lane_cnt[2] = cr;
		lane_cnt[3] = cl;
		lane_cnt[4] = color_mode ? cl : cb;
		if (color_mode) begin
			lane_div[0] = shared_max_q;
			lane_div[1] = shared_max_q;
			lane_div[2] = shared_max_q;
			lane_div[3] = shared_max_q;
			lane_div[4] = luma_max_q;
		end else begin
			lane_div[0] = gray_div;
			lane_div[1] = '0;
			lane_div[2] = '0;
			lane_div[3] = '0;
			lane_div[4] = gray_div;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [DW-1:0] prod;
		assign prod = {{HB{1'b0}}, lane_cnt[i]} * {{CB{1'b0}}, BARV};
		ihbh_div #(.DW(DW), .CB(CB)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (prod),
			.divisor  (lane_div[i]),
			.busy     (lane_busy[i]),
			.quot     (lane_q[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DIV && lane_busy == '0 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && lane_busy == '0 && out_free) out_h_q <= lane_q;
	end

	assign out_valid           = out_valid_q;
	assign gray_or_blue_height = out_h_q[0];
	assign green_height        = out_h_q[1];
	assign red_height          = out_h_q[2];
	assign luma_shared_height  = out_h_q[3];
	assign luma_own_height     = out_h_q[4];
endmodule
`default_nettype wire
